/* rtl/max_pool_2d_stream_defines.svh */
`ifndef MAX_POOL_2D_STREAM_DEFINES_SVH
`define MAX_POOL_2D_STREAM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MP2D_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MP2D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mp2d_pkg.sv */
`default_nettype none

package mp2d_pkg;

  // Register field widths.
  localparam int WIN_W     = 4;
  localparam int ROWS_W    = 10;
  localparam int COLS_W    = 10;
  localparam int CHAN_W    = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;

  // Default sizing of the block.
  localparam int DEF_MAX_IMAGE_COLS = 512;
  localparam int DEF_MAX_IMAGE_ROWS = 512;
  localparam int DEF_MAX_WINDOW     = 8;
  localparam int DEF_MAX_CHANNELS   = 1024;
  localparam int DEF_SAMPLE_WIDTH   = 16;

  // Register values after reset.
  localparam logic [WIN_W-1:0]  RST_WINDOW_ROWS   = WIN_W'(2);
  localparam logic [WIN_W-1:0]  RST_WINDOW_COLS   = WIN_W'(2);
  localparam logic [ROWS_W-1:0] RST_IMAGE_ROWS    = ROWS_W'(32);
  localparam logic [COLS_W-1:0] RST_IMAGE_COLS    = COLS_W'(32);
  localparam logic [CHAN_W-1:0] RST_CHANNEL_COUNT = CHAN_W'(1);

  // Result queue depth and its count width.
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_ROWS   = 3'd0,
    CFG_WINDOW_COLS   = 3'd1,
    CFG_IMAGE_ROWS    = 3'd2,
    CFG_IMAGE_COLS    = 3'd3,
    CFG_CHANNEL_COUNT = 3'd4
  } cfg_reg_e;

  // Per-sample command from the raster walker to the column store.
  typedef struct packed {
    logic use_store;
    logic first;
    logic emit;
    logic last;
  } mp2d_req_t;

endpackage

`default_nettype wire

/* rtl/mp2d_ctrl.sv */
`default_nettype none

module mp2d_ctrl #(
  parameter int MAX_IMAGE_COLS = mp2d_pkg::DEF_MAX_IMAGE_COLS,
  parameter int MAX_IMAGE_ROWS = mp2d_pkg::DEF_MAX_IMAGE_ROWS,
  parameter int MAX_WINDOW     = mp2d_pkg::DEF_MAX_WINDOW,
  parameter int MAX_CHANNELS   = mp2d_pkg::DEF_MAX_CHANNELS
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [mp2d_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [mp2d_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  wire                                  acc_i,
  output mp2d_pkg::mp2d_req_t                  req_o,
  output logic [$clog2(MAX_IMAGE_COLS)-1:0]    addr_o
);
  import mp2d_pkg::*;

  localparam int AW = $clog2(MAX_IMAGE_COLS);

  logic [WIN_W-1:0]  win_rows_q, win_cols_q;
  logic [ROWS_W-1:0] img_rows_q;
  logic [COLS_W-1:0] img_cols_q;
  logic [CHAN_W-1:0] chan_cnt_q;

  logic [WIN_W-1:0]  wr, wc;
  logic [ROWS_W-1:0] rows;
  logic [COLS_W-1:0] cols;
  logic [CHAN_W-1:0] chans;

  logic [COLS_W-1:0] col_q, col_d, col_start_q, col_start_d;
  logic [ROWS_W-1:0] row_q, row_d, row_start_q, row_start_d;
  logic [CHAN_W-1:0] chan_q, chan_d;
  logic [WIN_W-1:0]  cphase_q, cphase_d, rphase_q, rphase_d;
  logic [AW-1:0]     ocol_q, ocol_d;

  logic restart;
  logic col_fit, row_fit, row_end, col_end, chan_end;

  // Out-of-range register values act as the nearest legal value.
  always_comb begin
    wr = (win_rows_q == '0) ? WIN_W'(1) :
         (int'(win_rows_q) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : win_rows_q;
    wc = (win_cols_q == '0) ? WIN_W'(1) :
         (int'(win_cols_q) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : win_cols_q;
    rows = (img_rows_q == '0) ? ROWS_W'(1) :
           (int'(img_rows_q) > MAX_IMAGE_ROWS) ? ROWS_W'(MAX_IMAGE_ROWS) : img_rows_q;
    cols = (img_cols_q == '0) ? COLS_W'(1) :
           (int'(img_cols_q) > MAX_IMAGE_COLS) ? COLS_W'(MAX_IMAGE_COLS) : img_cols_q;
    chans = (chan_cnt_q == '0) ? CHAN_W'(1) :
            (int'(chan_cnt_q) > MAX_CHANNELS) ? CHAN_W'(MAX_CHANNELS) : chan_cnt_q;
  end

  always_comb begin
    restart = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WINDOW_ROWS, CFG_WINDOW_COLS, CFG_IMAGE_ROWS,
        CFG_IMAGE_COLS, CFG_CHANNEL_COUNT: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_rows_q <= RST_WINDOW_ROWS;
      win_cols_q <= RST_WINDOW_COLS;
      img_rows_q <= RST_IMAGE_ROWS;
      img_cols_q <= RST_IMAGE_COLS;
      chan_cnt_q <= RST_CHANNEL_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WINDOW_ROWS:   win_rows_q <= cfg_wdata_i[WIN_W-1:0];
        CFG_WINDOW_COLS:   win_cols_q <= cfg_wdata_i[WIN_W-1:0];
        CFG_IMAGE_ROWS:    img_rows_q <= cfg_wdata_i[ROWS_W-1:0];
        CFG_IMAGE_COLS:    img_cols_q <= cfg_wdata_i[COLS_W-1:0];
        CFG_CHANNEL_COUNT: chan_cnt_q <= cfg_wdata_i[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // A sample is pooled when the window it belongs to lies wholly inside
  // the image; the window start registers make that a single add and compare.
  always_comb begin
    col_fit  = ((COLS_W+1)'(col_start_q) + (COLS_W+1)'(wc)) <= (COLS_W+1)'(cols);
    row_fit  = ((ROWS_W+1)'(row_start_q) + (ROWS_W+1)'(wr)) <= (ROWS_W+1)'(rows);
    col_end  = ((COLS_W+1)'(col_q) + (COLS_W+1)'(wc)) >= (COLS_W+1)'(cols);
    row_end  = ((ROWS_W+1)'(row_q) + (ROWS_W+1)'(wr)) >= (ROWS_W+1)'(rows);
    chan_end = ((CHAN_W+1)'(chan_q) + (CHAN_W+1)'(1)) >= (CHAN_W+1)'(chans);

    req_o.use_store = col_fit && row_fit;
    req_o.first     = (rphase_q == '0) && (cphase_q == '0);
    req_o.emit      = col_fit && row_fit && (rphase_q == wr - WIN_W'(1)) &&
                      (cphase_q == wc - WIN_W'(1));
    req_o.last      = chan_end && row_end && col_end;
    addr_o          = ocol_q;
  end

  always_comb begin
    col_d       = col_q;
    col_start_d = col_start_q;
    row_d       = row_q;
    row_start_d = row_start_q;
    chan_d      = chan_q;
    cphase_d    = cphase_q;
    rphase_d    = rphase_q;
    ocol_d      = ocol_q;
    if (restart) begin
      col_d       = '0;
      col_start_d = '0;
      row_d       = '0;
      row_start_d = '0;
      chan_d      = '0;
      cphase_d    = '0;
      rphase_d    = '0;
      ocol_d      = '0;
    end else if (acc_i) begin
      if (((COLS_W+1)'(col_q) + (COLS_W+1)'(1)) >= (COLS_W+1)'(cols)) begin
        col_d       = '0;
        col_start_d = '0;
        cphase_d    = '0;
        ocol_d      = '0;
        if (((ROWS_W+1)'(row_q) + (ROWS_W+1)'(1)) >= (ROWS_W+1)'(rows)) begin
          row_d       = '0;
          row_start_d = '0;
          rphase_d    = '0;
          chan_d      = chan_end ? '0 : chan_q + CHAN_W'(1);
        end else begin
          row_d = row_q + ROWS_W'(1);
          if (((WIN_W+1)'(rphase_q) + (WIN_W+1)'(1)) >= (WIN_W+1)'(wr)) begin
            rphase_d    = '0;
            row_start_d = row_q + ROWS_W'(1);
          end else begin
            rphase_d = rphase_q + WIN_W'(1);
          end
        end
      end else begin
        col_d = col_q + COLS_W'(1);
        if (((WIN_W+1)'(cphase_q) + (WIN_W+1)'(1)) >= (WIN_W+1)'(wc)) begin
          cphase_d    = '0;
          col_start_d = col_q + COLS_W'(1);
          ocol_d      = ocol_q + AW'(1);
        end else begin
          cphase_d = cphase_q + WIN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      col_start_q <= '0;
      row_q       <= '0;
      row_start_q <= '0;
      chan_q      <= '0;
      cphase_q    <= '0;
      rphase_q    <= '0;
      ocol_q      <= '0;
    end else begin
      col_q       <= col_d;
      col_start_q <= col_start_d;
      row_q       <= row_d;
      row_start_q <= row_start_d;
      chan_q      <= chan_d;
      cphase_q    <= cphase_d;
      rphase_q    <= rphase_d;
      ocol_q      <= ocol_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/mp2d_colmax.sv */
`default_nettype none

module mp2d_colmax #(
  parameter int MAX_IMAGE_COLS = mp2d_pkg::DEF_MAX_IMAGE_COLS,
  parameter int SAMPLE_WIDTH   = mp2d_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  acc_i,
  input  mp2d_pkg::mp2d_req_t                  req_i,
  input  wire  [$clog2(MAX_IMAGE_COLS)-1:0]    addr_i,
  input  wire  [SAMPLE_WIDTH-1:0]              sample_i,
  output logic                                 busy_o,
  output logic                                 push_o,
  output logic                                 push_last_o,
  output logic [SAMPLE_WIDTH-2:0]              push_value_o
);
  import mp2d_pkg::*;

  localparam int AW = $clog2(MAX_IMAGE_COLS);
  localparam int VW = SAMPLE_WIDTH - 1;

  logic [VW-1:0] mem [MAX_IMAGE_COLS];

  logic [VW-1:0] rd_q;
  logic          s1_valid_q;
  mp2d_req_t     s1_req_q;
  logic [AW-1:0] s1_addr_q;
  logic [VW-1:0] s1_val_q;
  logic          fwd_q;
  logic [VW-1:0] fwd_data_q;

  logic [VW-1:0] in_val, base, new_max;
  logic          s1_we, fwd_d;

  // Negative samples count as zero.
  assign in_val = sample_i[SAMPLE_WIDTH-1] ? '0 : sample_i[VW-1:0];

  always_comb begin
    base    = fwd_q ? fwd_data_q : rd_q;
    new_max = (s1_req_q.first || (s1_val_q > base)) ? s1_val_q : base;
    s1_we   = s1_valid_q && s1_req_q.use_store;
    // The read issued this cycle sees the old entry if stage one writes it now.
    fwd_d   = s1_we && (s1_addr_q == addr_i);
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      rd_q <= mem[addr_i];
    end
    if (s1_we) begin
      mem[s1_addr_q] <= new_max;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_req_q   <= req_i;
      s1_addr_q  <= addr_i;
      s1_val_q   <= in_val;
      fwd_q      <= fwd_d;
      fwd_data_q <= new_max;
    end
  end

  assign busy_o       = s1_valid_q && s1_req_q.emit;
  assign push_o       = s1_valid_q && s1_req_q.emit;
  assign push_last_o  = s1_req_q.last;
  assign push_value_o = new_max;

endmodule

`default_nettype wire

/* rtl/mp2d_outq.sv */
`default_nettype none

module mp2d_outq #(
  parameter int DATA_W = mp2d_pkg::DEF_SAMPLE_WIDTH - 1
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 push_i,
  input  wire                                 push_last_i,
  input  wire  [DATA_W-1:0]                   push_value_i,
  input  wire                                 inflight_i,
  output logic                                space_o,
  output logic [mp2d_pkg::OUTQ_CNT_W-1:0]     count_o,
  output logic                                valid_o,
  input  wire                                 ready_i,
  output logic [DATA_W-1:0]                   value_o,
  output logic                                last_o
);
  import mp2d_pkg::*;

  logic [DATA_W:0]         entry [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]   wptr_q, rptr_q;
  logic [OUTQ_CNT_W-1:0]   cnt_q, cnt_d;
  logic                    pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign value_o = entry[rptr_q][DATA_W-1:0];
  assign last_o  = entry[rptr_q][DATA_W];
  assign count_o = cnt_q;
  // Room for a new item counts the result that may still be in flight.
  assign space_o = (cnt_q + OUTQ_CNT_W'(inflight_i)) < OUTQ_CNT_W'(OUTQ_DEPTH);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + OUTQ_CNT_W'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - OUTQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry[wptr_q] <= {push_last_i, push_value_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + OUTQ_PTR_W'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + OUTQ_PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/max_pool_2d_stream.sv */
// Non-overlapping 2-D max pooling over a stream of signed feature samples.
// Samples enter on the s_axis channel in raster order (channel, row, column),
// one per transfer. Each complete window yields one transfer on m_axis whose
// data is the window maximum clamped below at zero; tlast marks the last
// result of the tensor. Partial windows at the right and bottom are dropped.
// The configuration port takes one register write per cycle; any write to a
// defined register restarts the walk at the start of a tensor. Write it only
// while no results are outstanding.
// Throughput is one sample per cycle while the result queue has room. The
// column store is read at the edge that takes the sample; the next cycle
// compares, writes back and queues, and the queue's count raises m_axis_tvalid.
// Running maxima live in a single-port-write, one-read column store; a
// sample that hits the entry being written in the same cycle is forwarded.
// After reset the registers hold 2x2 windows over a 32x32 single-channel
// image; the column store needs no clearing since each window writes its
// entry before reading it. A four-entry result queue decouples the sides:
// when the receiver stalls, s_axis_tready drops once the queued results and
// the one still in flight fill the queue.
`include "max_pool_2d_stream_defines.svh"
`default_nettype none

module max_pool_2d_stream #(
  parameter int MAX_IMAGE_COLS = mp2d_pkg::DEF_MAX_IMAGE_COLS,
  parameter int MAX_IMAGE_ROWS = mp2d_pkg::DEF_MAX_IMAGE_ROWS,
  parameter int MAX_WINDOW     = mp2d_pkg::DEF_MAX_WINDOW,
  parameter int MAX_CHANNELS   = mp2d_pkg::DEF_MAX_CHANNELS,
  parameter int SAMPLE_WIDTH   = mp2d_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [mp2d_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire  [mp2d_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // sample, zero padded to whole bytes
  input  wire  [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // pooled_value, zero padded to whole bytes
  output logic [((SAMPLE_WIDTH-1+7)/8)*8-1:0]   m_axis_tdata,
  output logic                                  m_axis_tlast
);
  import mp2d_pkg::*;

  localparam int AW    = $clog2(MAX_IMAGE_COLS);
  localparam int VW    = SAMPLE_WIDTH - 1;
  localparam int OUT_W = ((SAMPLE_WIDTH-1+7)/8)*8;

  logic                  acc;
  mp2d_req_t             req;
  logic [AW-1:0]         addr;
  logic                  busy, push, push_last, space;
  logic [VW-1:0]         push_value, out_value;
  logic [OUTQ_CNT_W-1:0] q_count;

  assign s_axis_tready = space;
  assign acc           = s_axis_tvalid && space;

  mp2d_ctrl #(
    .MAX_IMAGE_COLS(MAX_IMAGE_COLS),
    .MAX_IMAGE_ROWS(MAX_IMAGE_ROWS),
    .MAX_WINDOW    (MAX_WINDOW),
    .MAX_CHANNELS  (MAX_CHANNELS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .acc_i      (acc),
    .req_o      (req),
    .addr_o     (addr)
  );

  mp2d_colmax #(
    .MAX_IMAGE_COLS(MAX_IMAGE_COLS),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) u_colmax (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .req_i       (req),
    .addr_i      (addr),
    .sample_i    (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .busy_o      (busy),
    .push_o      (push),
    .push_last_o (push_last),
    .push_value_o(push_value)
  );

  mp2d_outq #(
    .DATA_W(VW)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_last_i (push_last),
    .push_value_i(push_value),
    .inflight_i  (busy),
    .space_o     (space),
    .count_o     (q_count),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .value_o     (out_value),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'(out_value);

  `MP2D_ASSERT_SAME(a_no_overflow, clk_i, rst_ni, push, q_count != OUTQ_CNT_W'(OUTQ_DEPTH), "result queue overflow")
  `MP2D_ASSERT_NEXT(a_emit_pushes, clk_i, rst_ni, acc && req.emit, push, "completed window gave no result")
  `MP2D_ASSERT_NEXT(a_no_stray_push, clk_i, rst_ni, !acc, !push, "result without an accepted sample")

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import mp2d_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_LIMIT    = 3000;
  localparam int RAND_ITEMS    = 1900;
  localparam int NUM_REGS      = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_IDX_W'(CFG_CHANNEL_COUNT) + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX   = '1;

  typedef struct packed {
    logic [14:0] value;
    logic        last;
  } pooled_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [15:0]           data;
    logic                  chk;
    logic [14:0]           exp_value;
    logic                  exp_last;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_STALLS} rx_mode_e;

  // Columns: kind, register index, sample or write data, typed check, value, tensor end.
  localparam int DIR_ROWS = 27;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // Reset windows (2x2) over 32 rows, narrowed to two columns.
    '{ROW_WRITE,  CFG_IMAGE_COLS,    16'd2,    1'b0, 15'd0,      1'b0},
    '{ROW_SAMPLE, 3'd0,              16'h7FFF, 1'b0, 15'd0,      1'b0},
    '{ROW_SAMPLE, 3'd0,              16'h8000, 1'b0, 15'd0,      1'b0},
    '{ROW_SAMPLE, 3'd0,              16'h0001, 1'b0, 15'd0,      1'b0},
    '{ROW_SAMPLE, 3'd0,              16'hFFFF, 1'b1, 15'h7FFF,   1'b0},
    // A window of negative samples pools to zero.
    '{ROW_SAMPLE, 3'd0,              16'h8000, 1'b0, 15'd0,      1'b0},
    '{ROW_SAMPLE, 3'd0,              16'hFFFF, 1'b0, 15'd0,      1'b0},
    '{ROW_SAMPLE, 3'd0,              16'h8001, 1'b0, 15'd0,      1'b0},
    '{ROW_SAMPLE, 3'd0,              16'hC000, 1'b1, 15'd0,      1'b0},
    // Zero rows act as one row, so the 2-row window never fits.
    '{ROW_WRITE,  CFG_IMAGE_ROWS,    16'd0,    1'b0, 15'd0,      1'b0},
    '{ROW_SAMPLE, 3'd0,              16'h1234, 1'b0, 15'd0,      1'b0},
    '{ROW_SAMPLE, 3'd0,              16'h0000, 1'b0, 15'd0,      1'b0},
    '{ROW_SAMPLE, 3'd0,              16'h7FFF, 1'b0, 15'd0,      1'b0},
    // Zero window height acts as one; every pair of samples ends the tensor.
    '{ROW_WRITE,  CFG_WINDOW_ROWS,   16'd0,    1'b0, 15'd0,      1'b0},
    '{ROW_SAMPLE, 3'd0,              16'h0005, 1'b0, 15'd0,      1'b0},
    '{ROW_SAMPLE, 3'd0,              16'h0009, 1'b1, 15'd9,      1'b1},
    '{ROW_SAMPLE, 3'd0,              16'h7FFF, 1'b0, 15'd0,      1'b0},
    '{ROW_SAMPLE, 3'd0,              16'h7FFE, 1'b1, 15'h7FFF,   1'b1},
    // An oversized window width acts as the maximum and is wider than the image.
    '{ROW_WRITE,  CFG_WINDOW_COLS,   16'd15,   1'b0, 15'd0,      1'b0},
    '{ROW_SAMPLE, 3'd0,              16'h4000, 1'b0, 15'd0,      1'b0},
    '{ROW_WRITE,  CFG_WINDOW_COLS,   16'd1,    1'b0, 15'd0,      1'b0},
    '{ROW_SAMPLE, 3'd0,              16'h0003, 1'b1, 15'd3,      1'b0},
    // A write to an undefined index must not restart the walk.
    '{ROW_WRITE,  CFG_FIRST_UNUSED + 3'd1, 16'h07FF, 1'b0, 15'd0, 1'b0},
    '{ROW_SAMPLE, 3'd0,              16'h0004, 1'b1, 15'd4,      1'b1},
    '{ROW_WRITE,  CFG_CHANNEL_COUNT, 16'd0,    1'b0, 15'd0,      1'b0},
    '{ROW_SAMPLE, 3'd0,              16'h8000, 1'b1, 15'd0,      1'b0},
    '{ROW_SAMPLE, 3'd0,              16'h7FFF, 1'b1, 15'h7FFF,   1'b1}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata = '0;   // sample
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;        // pooled_value
  logic                 m_axis_tlast;

  // Mirror of the block's registers and raster walk.
  logic [WIN_W-1:0]  pool_win_rows = RST_WINDOW_ROWS;
  logic [WIN_W-1:0]  pool_win_cols = RST_WINDOW_COLS;
  logic [ROWS_W-1:0] pool_img_rows = RST_IMAGE_ROWS;
  logic [COLS_W-1:0] pool_img_cols = RST_IMAGE_COLS;
  logic [CHAN_W-1:0] pool_chans    = RST_CHANNEL_COUNT;
  logic [14:0]       col_max [DEF_MAX_IMAGE_COLS];
  int unsigned       pool_col = 0, pool_row = 0, pool_chan = 0;
  int unsigned       pool_wcol = 0, pool_wrow = 0, pool_ocol = 0;

  pooled_t     pooled_q [$];
  int unsigned errors = 0, results_seen = 0, tensors_seen = 0;
  int unsigned samples_sent = 0, rand_sent = 0, cfg_writes = 0;
  int unsigned burst_left = 0, idle_cycles = 0;
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_hold = 0, rx_stall_left = 0;

  max_pool_2d_stream dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned eff_size(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 15));
      1: return 16'($urandom_range(16'h8000, 16'hFFFF));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_reg(input cfg_reg_e r);
    case (r)
      CFG_WINDOW_ROWS, CFG_WINDOW_COLS: begin
        if ($urandom_range(0, 7) == 0) return CFG_W'($urandom_range(0, 15));
        return CFG_W'($urandom_range(1, 4));
      end
      CFG_IMAGE_ROWS: return CFG_W'($urandom_range(0, 12));
      CFG_IMAGE_COLS: begin
        if ($urandom_range(0, 5) == 0) return CFG_W'($urandom_range(13, 40));
        return CFG_W'($urandom_range(0, 12));
      end
      default: return CFG_W'($urandom_range(0, 3));
    endcase
  endfunction

  // Walks one sample through the pooling windows and reports a finished window.
  task automatic pool_step(input logic [15:0] smp, output logic got, output pooled_t res);
    int unsigned wr, wc, rows, cols, chans, used_c, used_r;
    logic [14:0] v;
    wr     = eff_size(pool_win_rows, DEF_MAX_WINDOW);
    wc     = eff_size(pool_win_cols, DEF_MAX_WINDOW);
    rows   = eff_size(pool_img_rows, DEF_MAX_IMAGE_ROWS);
    cols   = eff_size(pool_img_cols, DEF_MAX_IMAGE_COLS);
    chans  = eff_size(pool_chans, DEF_MAX_CHANNELS);
    used_c = (cols / wc) * wc;
    used_r = (rows / wr) * wr;
    v      = smp[15] ? 15'd0 : smp[14:0];
    got    = 1'b0;
    res    = '0;
    if (pool_col < used_c && pool_row < used_r && pool_ocol < DEF_MAX_IMAGE_COLS) begin
      if (pool_wrow == 0 && pool_wcol == 0) begin
        col_max[pool_ocol] = v;
      end else if (v > col_max[pool_ocol]) begin
        col_max[pool_ocol] = v;
      end
      if (pool_wrow == wr - 1 && pool_wcol == wc - 1) begin
        got       = 1'b1;
        res.value = col_max[pool_ocol];
        res.last  = (pool_chan == chans - 1) && (pool_row == used_r - 1) &&
                    (pool_col == used_c - 1);
      end
    end
    if (pool_col + 1 >= cols) begin
      pool_col  = 0;
      pool_wcol = 0;
      pool_ocol = 0;
      if (pool_row + 1 >= rows) begin
        pool_row  = 0;
        pool_wrow = 0;
        pool_chan = (pool_chan + 1 >= chans) ? 0 : pool_chan + 1;
      end else begin
        pool_row++;
        pool_wrow++;
        if (pool_wrow >= wr) pool_wrow = 0;
      end
    end else begin
      pool_col++;
      pool_wcol++;
      if (pool_wcol >= wc) begin
        pool_wcol = 0;
        pool_ocol++;
      end
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the write.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    logic hit;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_writes++;
    hit = 1'b1;
    case (idx)
      CFG_WINDOW_ROWS:   pool_win_rows = data[WIN_W-1:0];
      CFG_WINDOW_COLS:   pool_win_cols = data[WIN_W-1:0];
      CFG_IMAGE_ROWS:    pool_img_rows = data[ROWS_W-1:0];
      CFG_IMAGE_COLS:    pool_img_cols = data[COLS_W-1:0];
      CFG_CHANNEL_COUNT: pool_chans    = data[CHAN_W-1:0];
      default:           hit = 1'b0;
    endcase
    if (hit) begin
      pool_col  = 0;
      pool_row  = 0;
      pool_chan = 0;
      pool_wcol = 0;
      pool_wrow = 0;
      pool_ocol = 0;
    end
  endtask

  // Sender side: bursts of transfers separated by random gaps.
  task automatic send_sample(input logic [15:0] d);
    int unsigned gap;
    cfg_we_i <= 1'b0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    samples_sent++;
    @(negedge clk_i);
  endtask

  // Stops the sender and lets every outstanding result and the pipeline drain.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    cfg_we_i      <= 1'b0;
    while (pooled_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic feed(input int unsigned n);
    logic [15:0] smp;
    logic        got;
    pooled_t     res;
    repeat (n) begin
      smp = rand_sample();
      send_sample(smp);
      pool_step(smp, got, res);
      if (got) pooled_q.push_back(res);
      rand_sent++;
    end
  endtask

  task automatic set_all(input logic [CFG_W-1:0] wr, input logic [CFG_W-1:0] wc,
                         input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                         input logic [CFG_W-1:0] chans);
    wait_idle();
    cfg_write(CFG_WINDOW_ROWS, wr);
    cfg_write(CFG_WINDOW_COLS, wc);
    cfg_write(CFG_IMAGE_ROWS, rows);
    cfg_write(CFG_IMAGE_COLS, cols);
    cfg_write(CFG_CHANNEL_COUNT, chans);
  endtask

  // Receiver side: the stall pattern switches between modes at random.
  always @(negedge clk_i) begin
    if (rx_hold == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_hold = $urandom_range(20, 120);
    end
    rx_hold--;
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 7) != 0);
      default: begin
        if (rx_stall_left != 0) begin
          rx_stall_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 9) == 0) rx_stall_left = $urandom_range(1, 20);
        end
      end
    endcase
  end

  always @(posedge clk_i) begin : result_check
    pooled_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pooled_q.size() == 0) begin
        $error("result with none expected: pooled_value %0d, tensor_done %0b",
               m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = pooled_q.pop_front();
        results_seen++;
        if (want.last) tensors_seen++;
        if (m_axis_tdata !== {1'b0, want.value}) begin
          $error("pooled_value: expected %0d, actual %0d", want.value, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("tensor_done: expected %0b, actual %0b", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Ends the run when no transfer or register write happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    dir_row_t    row;
    logic        got;
    pooled_t     res;
    int unsigned tensor, n;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      if (row.kind == ROW_WRITE) begin
        wait_idle();
        cfg_write(row.idx, row.data[CFG_W-1:0]);
      end else begin
        send_sample(row.data);
        pool_step(row.data, got, res);
        if (row.chk) begin
          pooled_q.push_back('{value: row.exp_value, last: row.exp_last});
        end else if (got) begin
          pooled_q.push_back(res);
        end
      end
    end

    // Widest image with one-column windows fills the whole column store.
    set_all(1, 1, 1023, 1023, 1);
    feed(514);
    // All sizes zero, channel count above the maximum: tensor ends after 1024.
    set_all(0, 0, 0, 0, 2047);
    feed(1026);
    // Largest windows with a dropped bottom row and right column.
    set_all(15, 8, 9, 17, 1);
    feed(153);

    while (rand_sent < RAND_ITEMS) begin
      wait_idle();
      for (int r = 0; r < NUM_REGS; r++) begin
        if ($urandom_range(0, 4) != 0) cfg_write(CFG_IDX_W'(r), rand_reg(cfg_reg_e'(r)));
      end
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(CFG_IDX_W'($urandom_range(int'(CFG_FIRST_UNUSED), int'(CFG_LAST_INDEX))),
                  CFG_W'($urandom));
      end
      tensor = eff_size(pool_img_rows, DEF_MAX_IMAGE_ROWS) *
               eff_size(pool_img_cols, DEF_MAX_IMAGE_COLS) *
               eff_size(pool_chans, DEF_MAX_CHANNELS);
      // Mostly whole tensors; otherwise a partial one cut short by the next restart.
      if (tensor <= 60 && $urandom_range(0, 3) != 0) n = tensor * $urandom_range(1, 2);
      else n = $urandom_range(1, 150);
      feed(n);
    end

    wait_idle();
    repeat (16) @(posedge clk_i);
    $display("Sent %0d samples with %0d register writes; checked %0d pooled results",
             samples_sent, cfg_writes, results_seen);
    $display("including %0d tensor ends, under reset, extreme and random window setups.",
             tensors_seen);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
